FILE: sv/cge_pkg.sv
package cge_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int PIXEL_BITS = 16;
  localparam int HEIGHT_CAP = 4096;

  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int FW_BITS    = $clog2(MAX_WIDTH + 1);
  localparam int FH_BITS    = 13;
  localparam int WREG_BITS  = 12;
  localparam int CFG_BITS   = 13;
  localparam int SLOPE_BITS = PIXEL_BITS + 1;

  localparam int FW_RESET   = 640;
  localparam int FH_RESET   = 480;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                  rd_en;
    logic                  wr_en;
    logic                  wr_bank;
    logic [COL_BITS-1:0]   addr_a;
    logic [COL_BITS-1:0]   addr_b;
    logic [PIXEL_BITS-1:0] wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [1:0][PIXEL_BITS-1:0] rd_a;
    logic [1:0][PIXEL_BITS-1:0] rd_b;
  } mem_rsp_t;

endpackage

FILE: sv/cge_in_if.sv
interface cge_in_if;
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic [cge_pkg::PIXEL_BITS-1:0] pixel;

  modport source (output valid, op, pixel, input ready);
  modport sink (input valid, op, pixel, output ready);
endinterface

FILE: sv/cge_out_if.sv
interface cge_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cge_pkg::SLOPE_BITS-1:0] x_slope;
  logic signed [cge_pkg::SLOPE_BITS-1:0] y_slope;
  logic                                  frame_last;

  modport source (output valid, x_slope, y_slope, frame_last, input ready);
  modport sink (input valid, x_slope, y_slope, frame_last, output ready);
endinterface

FILE: sv/cge_line_store.sv
module cge_line_store (
  input  logic              clk_i,
  input  cge_pkg::mem_req_t req_i,
  output cge_pkg::mem_rsp_t rsp_o
);

  logic [1:0][cge_pkg::PIXEL_BITS-1:0] rd_a_q;
  logic [1:0][cge_pkg::PIXEL_BITS-1:0] rd_b_q;

  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic [cge_pkg::PIXEL_BITS-1:0] bank_mem [cge_pkg::MAX_WIDTH];

    always_ff @(posedge clk_i) begin
      if (req_i.wr_en && (req_i.wr_bank == 1'(b))) begin
        bank_mem[req_i.addr_a] <= req_i.wr_data;
      end
      if (req_i.rd_en) begin
        rd_a_q[b] <= bank_mem[req_i.addr_a];
        rd_b_q[b] <= bank_mem[req_i.addr_b];
      end
    end
  end

  assign rsp_o.rd_a = rd_a_q;
  assign rsp_o.rd_b = rd_b_q;

endmodule

FILE: sv/centered_gradient_edges.sv
// Raster image gradient: one pixel word (or drain word) is taken per clock while the output
// is not stalled; each result word passes through the stage-1 and output registers, with
// results for row r appearing while row r+1 streams in; after the frame, frame_width drain
// words flush the last row and the final result carries frame_last. Two line banks of MAX_WIDTH
// pixels, each with one write and two registered read ports, hold the previous two rows; one
// read at the current column and one at the next column per word set the one-word-per-clock
// pace, and the left neighbor is kept in a register. The banks need no clearing after reset.
module centered_gradient_edges (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [cge_pkg::CFG_BITS-1:0] cfg_data_i,
  cge_in_if.sink                       pix_i,
  cge_out_if.source                    grad_o
);

  typedef struct packed {
    logic                           col_zero;
    logic                           col_last;
    logic                           row_zero;
    logic                           last_row;
    logic                           flag;
    logic                           cur_bank;
    logic [cge_pkg::PIXEL_BITS-1:0] below;
  } s1_t;

  logic [cge_pkg::FW_BITS-1:0]    fw_q;
  logic [cge_pkg::FH_BITS-1:0]    fh_q;
  logic [cge_pkg::COL_BITS-1:0]   in_col_q, in_col_d;
  logic [cge_pkg::FH_BITS-1:0]    in_row_q, in_row_d;
  logic                           s1_valid_q;
  s1_t                            s1_q, s1_d;
  logic [cge_pkg::PIXEL_BITS-1:0] left_q;
  logic                           out_valid_q;
  logic signed [cge_pkg::SLOPE_BITS-1:0] x_q, y_q, x_d, y_d;
  logic                           last_q;

  logic [cge_pkg::WREG_BITS-1:0]  w_raw;
  logic [cge_pkg::FH_BITS-1:0]    h_raw;
  logic [cge_pkg::FW_BITS-1:0]    w_clamp;
  logic [cge_pkg::FH_BITS-1:0]    h_clamp;

  logic s1_move, accept, col_last, draining, is_drain, step, emit, wr;

  cge_pkg::mem_req_t mem_req;
  cge_pkg::mem_rsp_t mem_rsp;

  logic [cge_pkg::PIXEL_BITS-1:0] center, right, up;

  // clamp register writes
  always_comb begin
    w_raw = cfg_data_i[cge_pkg::WREG_BITS-1:0];
    h_raw = cfg_data_i[cge_pkg::FH_BITS-1:0];
    if (32'(w_raw) < 2) begin
      w_clamp = cge_pkg::FW_BITS'(2);
    end else if (32'(w_raw) > cge_pkg::MAX_WIDTH) begin
      w_clamp = cge_pkg::FW_BITS'(cge_pkg::MAX_WIDTH);
    end else begin
      w_clamp = cge_pkg::FW_BITS'(w_raw);
    end
    if (32'(h_raw) < 2) begin
      h_clamp = cge_pkg::FH_BITS'(2);
    end else if (32'(h_raw) > cge_pkg::HEIGHT_CAP) begin
      h_clamp = cge_pkg::FH_BITS'(cge_pkg::HEIGHT_CAP);
    end else begin
      h_clamp = h_raw;
    end
  end

  assign s1_move     = !out_valid_q || grad_o.ready;
  assign pix_i.ready = !s1_valid_q || s1_move;
  assign accept      = pix_i.valid && pix_i.ready;

  assign col_last = cge_pkg::FW_BITS'(in_col_q) >= (fw_q - cge_pkg::FW_BITS'(1));
  assign draining = in_row_q >= fh_q;
  assign is_drain = pix_i.op == cge_pkg::OP_DRAIN;
  assign step     = draining ? is_drain : !is_drain;
  assign emit     = draining ? is_drain : (!is_drain && (in_row_q != '0));
  assign wr       = !draining && !is_drain;

  always_comb begin
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    if (accept && step) begin
      if (col_last) begin
        in_col_d = '0;
        in_row_d = draining ? '0 : in_row_q + cge_pkg::FH_BITS'(1);
      end else begin
        in_col_d = in_col_q + cge_pkg::COL_BITS'(1);
      end
    end
  end

  always_comb begin
    mem_req.rd_en   = accept;
    mem_req.wr_en   = accept && wr;
    mem_req.wr_bank = in_row_q[0];
    mem_req.addr_a  = in_col_q;
    mem_req.addr_b  = in_col_q + cge_pkg::COL_BITS'(1);
    mem_req.wr_data = pix_i.pixel;
  end

  cge_line_store u_line_store (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

  always_comb begin
    s1_d.col_zero = in_col_q == '0;
    s1_d.col_last = col_last;
    s1_d.row_zero = in_row_q == cge_pkg::FH_BITS'(1);
    s1_d.last_row = draining;
    s1_d.flag     = draining && col_last;
    s1_d.cur_bank = !in_row_q[0];
    s1_d.below    = pix_i.pixel;
  end

  always_comb begin
    center = mem_rsp.rd_a[s1_q.cur_bank];
    right  = mem_rsp.rd_b[s1_q.cur_bank];
    up     = mem_rsp.rd_a[!s1_q.cur_bank];
    priority if (s1_q.col_zero) begin
      x_d = $signed({1'b0, right}) - $signed({1'b0, center});
    end else if (s1_q.col_last) begin
      x_d = $signed({1'b0, center}) - $signed({1'b0, left_q});
    end else begin
      x_d = $signed({1'b0, right}) - $signed({1'b0, left_q});
    end
    priority if (s1_q.row_zero) begin
      y_d = $signed({1'b0, s1_q.below}) - $signed({1'b0, center});
    end else if (s1_q.last_row) begin
      y_d = $signed({1'b0, center}) - $signed({1'b0, up});
    end else begin
      y_d = $signed({1'b0, s1_q.below}) - $signed({1'b0, up});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q        <= cge_pkg::FW_BITS'(cge_pkg::FW_RESET);
      fh_q        <= cge_pkg::FH_BITS'(cge_pkg::FH_RESET);
      in_col_q    <= '0;
      in_row_q    <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cge_pkg::CFG_FRAME_WIDTH:  fw_q <= w_clamp;
          cge_pkg::CFG_FRAME_HEIGHT: fh_q <= h_clamp;
          default: ;
        endcase
      end
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      if (accept) begin
        s1_valid_q <= emit;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && s1_move) begin
        out_valid_q <= 1'b1;
      end else if (grad_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s1_valid_q && s1_move) begin
      left_q <= center;
      x_q    <= x_d;
      y_q    <= y_d;
      last_q <= s1_q.flag;
    end
  end

  assign grad_o.valid      = out_valid_q;
  assign grad_o.x_slope    = x_q;
  assign grad_o.y_slope    = y_q;
  assign grad_o.frame_last = last_q;

endmodule
